// ===== hw/rtl/bmxq_pkg.sv =====
// Package for the bounded maximum-XOR query block.
// Holds the payload widths and the operation codes; depends on nothing.
package bmxq_pkg;

  localparam int unsigned VALUE_BITS = 30;
  localparam int unsigned OP_W       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef logic [VALUE_BITS-1:0] value_t;

endpackage

// ===== hw/rtl/bmxq_if.sv =====
// Handshake interfaces for the request and result channels.
// Depends on bmxq_pkg for payload widths.
interface bmxq_req_if;
  logic                          valid;
  logic                          ready;
  logic [bmxq_pkg::OP_W-1:0]     op;
  logic [bmxq_pkg::VALUE_BITS-1:0] value;
  logic [bmxq_pkg::VALUE_BITS-1:0] limit;

  modport source (output valid, output op, output value, output limit, input ready);
  modport sink   (input valid, input op, input value, input limit, output ready);
endinterface

interface bmxq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [bmxq_pkg::VALUE_BITS-1:0] max_xor;

  modport source (output valid, output found, output max_xor, input ready);
  modport sink   (input valid, input found, input max_xor, output ready);
endinterface

// ===== hw/rtl/bmxq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmxq_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bounded_max_xor_query_top.sv =====
// Bounded maximum-XOR query block. It keeps up to CAPACITY values in one
// synchronous RAM, filled in order by insert items; a clear item resets the
// fill count. A query item scans the filled entries, one RAM read per cycle,
// and returns the largest (operand XOR v) over stored v not above the limit,
// with found=0 and max_xor=0 when no entry qualifies. Insert, clear and the
// unused op code produce no result. A query holds the request channel
// while it scans and until its result is shown (the RAM read port sets the
// pace: one entry per cycle, plus the read and compare stages and the drain
// check), longer if the previous result has not been taken. The result sits
// in an output register, so the next item is accepted while it waits. An
// insert into a full store is dropped. No clearing pass is needed after
// reset: only entries below the fill count are ever read.
// Depends on bmxq_pkg, bmxq_if and bmxq_ram.
module bounded_max_xor_query_top #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bmxq_req_if.sink   req_i,
  bmxq_rsp_if.source rsp_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           idx_q, idx_d;
  bmxq_pkg::value_t        operand_q, limit_q;
  logic                    rvld_q;
  logic                    s1_vld_q, s1_qual_q;
  bmxq_pkg::value_t        s1_x_q;
  logic                    hit_q;
  bmxq_pkg::value_t        best_q;
  logic                    out_vld_q, found_q;
  bmxq_pkg::value_t        max_xor_q;

  logic                    req_acc, out_free, ram_we, rd_en, scan_end;
  bmxq_pkg::value_t        rdata;

  // Accept items only between queries.
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  // Output slot is free when empty or being taken this cycle.
  assign out_free = !out_vld_q || rsp_o.ready;

  // Write the next free entry; drop the insert when the store is full.
  assign ram_we = req_acc && (req_i.op == bmxq_pkg::OP_INSERT) &&
                  (count_q < CW'(CAPACITY));

  // Issue one read per cycle until every filled entry has been read.
  assign rd_en    = (state_q == ST_SCAN) && (idx_q != count_q);
  assign scan_end = (state_q == ST_SCAN) && (idx_q == count_q) && !rvld_q && !s1_vld_q;

  bmxq_ram #(
    .WIDTH (bmxq_pkg::VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (req_i.value),
    .re_i    (rd_en),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    if (rd_en) begin
      idx_d = idx_q + CW'(1);
    end
    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          priority if (req_i.op == bmxq_pkg::OP_CLEAR) begin
            count_d = '0;
          end else if (ram_we) begin
            count_d = count_q + CW'(1);
          end else if (req_i.op == bmxq_pkg::OP_QUERY) begin
            idx_d   = '0;
            state_d = ST_SCAN;
          end else begin
            count_d = count_q;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      rvld_q    <= 1'b0;
      s1_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      rvld_q   <= rd_en;
      s1_vld_q <= rvld_q;
      // Fold each qualifying entry into the running best.
      if (req_acc && (req_i.op == bmxq_pkg::OP_QUERY)) begin
        hit_q <= 1'b0;
      end else if (s1_vld_q && s1_qual_q) begin
        hit_q <= 1'b1;
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers: operand latch, compare stage, running best, result.
  always_ff @(posedge clk_i) begin
    if (req_acc && (req_i.op == bmxq_pkg::OP_QUERY)) begin
      operand_q <= req_i.value;
      limit_q   <= req_i.limit;
    end
    s1_qual_q <= (rdata <= limit_q);
    s1_x_q    <= rdata ^ operand_q;
    if (s1_vld_q && s1_qual_q && (!hit_q || (s1_x_q > best_q))) begin
      best_q <= s1_x_q;
    end
    if ((state_q == ST_DONE) && out_free) begin
      found_q   <= hit_q;
      max_xor_q <= hit_q ? best_q : '0;
    end
  end

  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.found   = found_q;
  assign rsp_o.max_xor = max_xor_q;

  // Fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // Only filled entries are read.
  a_read_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (idx_q < count_q))
    else $error("read beyond fill count");

  // A query starts its scan with no hit carried over.
  a_query_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && (req_i.op == bmxq_pkg::OP_QUERY)) |=> (state_q == ST_SCAN) && !hit_q)
    else $error("query did not start a clean scan");

  // A finished result waits while the previous one is still held.
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && out_vld_q && !rsp_o.ready) |=> (state_q == ST_DONE))
    else $error("result overwrote an untaken result");

  // The store does not change under a scan.
  a_scan_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |=> $stable(count_q))
    else $error("fill count changed during scan");

endmodule

// ===== verif/bounded_max_xor_query_top_tb.sv =====
// Self-checking testbench for bounded_max_xor_query_top: drives clear, insert,
// query and unused items, predicts each query answer and checks it per field.
// Depends on bmxq_pkg, the bmxq_if interfaces and the block's RTL.
module bounded_max_xor_query_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned                CAPACITY     = 1024;
  localparam logic [bmxq_pkg::OP_W-1:0]  OP_UNUSED    = 2'd3;
  localparam bmxq_pkg::value_t           VALUE_MAX    = '1;
  localparam int unsigned                IDLE_PCT     = 27;
  localparam int unsigned                HOLD_CYCLES  = 600;
  localparam int unsigned                DRAIN_CYCLES = 16;
  localparam int unsigned                CYCLE_LIMIT  = 8_000_000;

  // One query answer as the block presents it.
  typedef struct packed {
    logic             found;
    bmxq_pkg::value_t max_xor;
  } answer_t;

  logic clk_i;
  logic rst_ni;

  bmxq_req_if req_if ();
  bmxq_rsp_if rsp_if ();

  bounded_max_xor_query_top #(
    .CAPACITY (CAPACITY)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the value store: filled in order, emptied by a clear.
  bmxq_pkg::value_t store_mem [CAPACITY];
  int unsigned      store_fill;

  // Answers owed by the block, oldest first.
  answer_t     pending_answers [$];

  int unsigned err_count    = 0;
  int unsigned cycle_count  = 0;
  int unsigned items_sent   = 0;
  int unsigned n_clear      = 0;
  int unsigned n_insert     = 0;
  int unsigned n_dropped    = 0;
  int unsigned n_query      = 0;
  int unsigned n_found      = 0;
  int unsigned n_ignored    = 0;
  int unsigned answers_seen = 0;

  // Random idling on both channels; cleared for the stretch without gaps.
  bit          idle_on;

  // Long result hold-off: the test bumps hold_requests, the ready process
  // owns the countdown.
  int unsigned hold_requests = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;

  // ---------------------------------------------------------------------------
  // Clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a correct run ends far below this count.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d answers still owed.",
               cycle_count, pending_answers.size());
      $display("[bounded_max_xor_query_top] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Scan the shadow store for the largest operand XOR over entries within bound.
  function automatic answer_t best_xor_under(bmxq_pkg::value_t operand,
                                             bmxq_pkg::value_t bound);
    answer_t          best;
    bmxq_pkg::value_t x;
    best = '0;
    for (int unsigned i = 0; i < store_fill; i++) begin
      if (store_mem[i] <= bound) begin
        x = store_mem[i] ^ operand;
        if (!best.found || x > best.max_xor) best.max_xor = x;
        best.found = 1'b1;
      end
    end
    return best;
  endfunction

  // Apply one accepted item to the shadow state; queue the answer of a query.
  function automatic void commit_item(logic [bmxq_pkg::OP_W-1:0] op,
                                      bmxq_pkg::value_t operand,
                                      bmxq_pkg::value_t bound);
    answer_t ans;
    case (op)
      bmxq_pkg::OP_CLEAR: begin
        store_fill = 0;
        n_clear++;
        items_sent++;
      end
      bmxq_pkg::OP_INSERT: begin
        n_insert++;
        items_sent++;
        // A full store drops the insert without a trace.
        if (store_fill < CAPACITY) begin
          store_mem[store_fill] = operand;
          store_fill++;
        end else begin
          n_dropped++;
        end
      end
      bmxq_pkg::OP_QUERY: begin
        n_query++;
        items_sent++;
        ans = best_xor_under(operand, bound);
        if (ans.found) n_found++;
        pending_answers = {pending_answers, ans};
      end
      default: begin
        // Unused code: no state change, no answer.
        n_ignored++;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    err_count++;
    if (err_count <= 40) begin
      $display("Mismatch at cycle %0d, answer %0d: %s, want 0x%08h, got 0x%08h",
               cycle_count, answers_seen, what, want, got);
    end
  endtask

  // Compare each answer taken from the block with the oldest one owed.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        report_mismatch("answer with no query pending", 0, 32'(rsp_if.max_xor));
      end else begin
        want = pending_answers.pop_front();
        if (rsp_if.found !== want.found)
          report_mismatch("found", 32'(want.found), 32'(rsp_if.found));
        if (rsp_if.max_xor !== want.max_xor)
          report_mismatch("max_xor", 32'(want.max_xor), 32'(rsp_if.max_xor));
      end
    end
  end

  // Result ready: a long hold-off when asked, otherwise random gaps or none.
  always @(posedge clk_i) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one item and hold it until accepted. Valid stays high afterwards so
  // that back-to-back items need no second assignment in the same step; any
  // other wait must lower it first.
  task automatic send_item(logic [bmxq_pkg::OP_W-1:0] op, bmxq_pkg::value_t operand,
                           bmxq_pkg::value_t bound);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.op    <= op;
    req_if.value <= operand;
    req_if.limit <= bound;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    commit_item(op, operand, bound);
  endtask

  // Lower valid and wait until every owed answer is in, then let the tail pass.
  task automatic drain_answers();
    req_if.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mix of full-width values and values near both ends, so that duplicates
  // and exact limit hits turn up often.
  function automatic bmxq_pkg::value_t rand_value();
    bmxq_pkg::value_t v;
    case ($urandom_range(3))
      0:       v = bmxq_pkg::value_t'($urandom_range(255));
      1:       v = VALUE_MAX - bmxq_pkg::value_t'($urandom_range(255));
      default: v = bmxq_pkg::value_t'($urandom());
    endcase
    return v;
  endfunction

  // Query bound: often a stored value or one below it, so the edge of the
  // comparison is exercised, sometimes the extremes.
  function automatic bmxq_pkg::value_t pick_bound();
    bmxq_pkg::value_t v;
    int unsigned      roll;
    roll = $urandom_range(99);
    if (store_fill != 0 && roll < 45) begin
      v = store_mem[$urandom_range(store_fill - 1)];
      if (roll < 15 && v != '0) v = v - bmxq_pkg::value_t'(1);
      return v;
    end
    if (roll < 55) return '0;
    if (roll < 65) return VALUE_MAX;
    return rand_value();
  endfunction

  // Query operand: a stored value gives a zero XOR, its inverse the maximum.
  function automatic bmxq_pkg::value_t pick_operand();
    int unsigned roll;
    roll = $urandom_range(99);
    if (store_fill != 0 && roll < 25) return store_mem[$urandom_range(store_fill - 1)];
    if (store_fill != 0 && roll < 35) return ~store_mem[$urandom_range(store_fill - 1)];
    return rand_value();
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty set, extreme values and bounds, duplicates, the unused code and
  // a bound below every stored value.
  task automatic test_directed_cases();
    send_item(bmxq_pkg::OP_QUERY,  VALUE_MAX, VALUE_MAX);   // empty set: nothing found
    send_item(OP_UNUSED,           VALUE_MAX, VALUE_MAX);   // ignored on empty set
    send_item(bmxq_pkg::OP_INSERT, '0, VALUE_MAX);
    send_item(bmxq_pkg::OP_QUERY,  '0, '0);                 // bound zero admits zero
    send_item(bmxq_pkg::OP_QUERY,  VALUE_MAX, '0);
    send_item(bmxq_pkg::OP_INSERT, VALUE_MAX, '0);
    send_item(bmxq_pkg::OP_QUERY,  '0, VALUE_MAX);
    send_item(bmxq_pkg::OP_QUERY,  VALUE_MAX, VALUE_MAX);
    send_item(bmxq_pkg::OP_INSERT, VALUE_MAX, VALUE_MAX);   // duplicate entry
    send_item(bmxq_pkg::OP_QUERY,  30'h1555_5555, VALUE_MAX - bmxq_pkg::value_t'(1));
    send_item(OP_UNUSED,           30'h2AAA_AAAA, '0);      // must not insert
    send_item(bmxq_pkg::OP_QUERY,  30'h2AAA_AAAA, VALUE_MAX);
    send_item(bmxq_pkg::OP_CLEAR,  VALUE_MAX, VALUE_MAX);
    send_item(bmxq_pkg::OP_QUERY,  '0, VALUE_MAX);          // cleared: nothing found
    send_item(bmxq_pkg::OP_INSERT, 30'd200, '0);
    send_item(bmxq_pkg::OP_INSERT, 30'd100, '0);
    send_item(bmxq_pkg::OP_QUERY,  30'd7, 30'd99);          // bound below all entries
    send_item(bmxq_pkg::OP_QUERY,  30'd200, 30'd100);       // bound equal to an entry
    send_item(bmxq_pkg::OP_QUERY,  30'd100, 30'd200);
    send_item(bmxq_pkg::OP_CLEAR,  '0, '0);
  endtask

  // Hold the result side off while queries keep coming, so the output
  // register fills and the block has to stall its request side.
  task automatic test_backpressure();
    send_item(bmxq_pkg::OP_CLEAR, rand_value(), rand_value());
    repeat (6) send_item(bmxq_pkg::OP_INSERT, rand_value(), rand_value());
    hold_requests++;
    repeat (12) send_item(bmxq_pkg::OP_QUERY, pick_operand(), pick_bound());
  endtask

  // Mostly clear-fill-query sequences with random content and sizes, small
  // sizes far more often than large; the rest is noise of any code and
  // queries on a store that was not cleared first.
  task automatic test_random_traffic(int unsigned n_items, bit with_idle);
    int unsigned               goal;
    int unsigned               fill;
    int unsigned               roll;
    logic [bmxq_pkg::OP_W-1:0] any_op;
    idle_on = with_idle;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      case ($urandom_range(19))
        0: begin
          repeat ($urandom_range(1, 4)) begin
            any_op = bmxq_pkg::OP_W'($urandom_range(3));
            send_item(any_op, rand_value(), rand_value());
          end
        end
        1: begin
          repeat ($urandom_range(0, 5))
            send_item(bmxq_pkg::OP_INSERT, rand_value(), rand_value());
          send_item(bmxq_pkg::OP_QUERY, pick_operand(), pick_bound());
        end
        default: begin
          send_item(bmxq_pkg::OP_CLEAR, rand_value(), rand_value());
          roll = $urandom_range(99);
          if (roll < 70)      fill = $urandom_range(0, 16);
          else if (roll < 95) fill = $urandom_range(17, 64);
          else                fill = $urandom_range(65, 300);
          repeat (fill) send_item(bmxq_pkg::OP_INSERT, rand_value(), rand_value());
          repeat ($urandom_range(1, 8))
            send_item(bmxq_pkg::OP_QUERY, pick_operand(), pick_bound());
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.op     = bmxq_pkg::OP_CLEAR;
    req_if.value  = '0;
    req_if.limit  = '0;
    rsp_if.ready  = 1'b0;
    idle_on       = 1'b1;
    store_fill    = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_backpressure();
    test_random_traffic(430, 1'b1);
    test_random_traffic(100, 1'b0);
    drain_answers();

    $display("Sent %0d clears, %0d inserts (%0d dropped on a full store), %0d unused codes.",
             n_clear, n_insert, n_dropped, n_ignored);
    $display("Checked %0d query answers, %0d with a value in bound; %0d mismatches.",
             answers_seen, n_found, err_count);
    if (err_count == 0) begin
      $display("[bounded_max_xor_query_top] OK");
    end else begin
      $display("[bounded_max_xor_query_top] ERROR");
    end
    $finish;
  end

endmodule
